// File: sv/wtsp_pkg.sv
`default_nettype none
package wtsp_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_CAMERA_X      = 3'd0;
  localparam logic [2:0] REG_CAMERA_Y      = 3'd1;
  localparam logic [2:0] REG_CAMERA_Z      = 3'd2;
  localparam logic [2:0] REG_VIEW_YAW      = 3'd3;
  localparam logic [2:0] REG_VIEW_PITCH    = 3'd4;
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd5;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd6;
  localparam logic [2:0] REG_FIELD_OF_VIEW = 3'd7;

  // quarter-wave sine polynomial, Q30
  localparam logic [30:0] SIN_A = 31'd1686629713;
  localparam logic [30:0] SIN_B = 31'd688904866;
  localparam logic [30:0] SIN_C = 31'd76016977;
  localparam logic [16:0] QUARTER = 17'd32768;

  localparam int DEP_W = 42;   // depth in Q.24
  localparam int MAG_W = 43;   // magnitude of right/up in Q.24
  localparam int QT_W  = 48;   // ratio magnitude
  localparam int K_W   = 62;   // projection scale

  // depth * 10 >= 2^38
  localparam logic signed [58:0] VIS_MIN = 59'sd27487790695;

  typedef struct packed {
    logic                  ready;
    logic signed [23:0]    camera_x;
    logic signed [23:0]    camera_y;
    logic signed [23:0]    camera_z;
    logic signed [31:0]    fx;
    logic signed [31:0]    fy;
    logic signed [31:0]    sp;
    logic signed [31:0]    cy;
    logic signed [31:0]    sy;
    logic signed [31:0]    ux;
    logic signed [31:0]    uy;
    logic signed [31:0]    cp;
    logic [K_W-1:0]        k;
    logic [15:0]           centre_x;
    logic [15:0]           centre_y;
  } cam_t;

endpackage
`default_nettype wire

// File: sv/world_to_screen_projection_top.sv
// World point to screen projection.
// Input word on s_axis: three signed Q16.8 coordinates of a world point.
// Output word on m_axis: screen_x and screen_y in 1/16 pixel (saturated to 24 bits),
// with tuser high when the point lies at least 0.1 units in front of the camera;
// a point behind that plane comes out with tuser low and both coordinates zero.
// Camera position, yaw, pitch, screen size and field of view come in on the cfg
// write port. After reset and after every write, a setup sequencer works out
// the camera sine/cosine terms and the projection scale (one
// quotient bit per cycle); s_axis_tready stays low during that time.
// Afterwards one word is accepted per cycle while the output is not stalled.
// Each result passes through the pipeline to the output register; its depth
// holds the 48-stage ratio divider plus the product and rounding stages around it.
// When the receiver drops m_axis_tready while a result is waiting, the whole
// pipeline holds and s_axis_tready drops with it; nothing is lost or repeated.
`default_nettype none
module world_to_screen_projection_top import wtsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // point_x, point_y, point_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // screen_x, screen_y
  output logic        m_axis_tuser,   // visible
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int PIPE_N = QT_W + 8;

  cam_t cam;

  wtsp_setup u_setup (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cam       (cam)
  );

  function automatic logic [MAG_W-1:0] mag14(input logic signed [58:0] v);
    logic [58:0] m;
    logic [58:0] r;
    m = v[58] ? 59'(-v) : 59'(v);
    r = v[58] ? (m + 59'd8191) : (m + 59'd8192);
    return r[MAG_W+13:14];
  endfunction

  logic adv;
  logic [PIPE_N-1:0] pv;
  logic out_vld;

  assign adv           = !out_vld || m_axis_tready;
  assign s_axis_tready = adv && cam.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv      <= '0;
      out_vld <= 1'b0;
    end else if (adv) begin
      pv      <= {pv[PIPE_N-2:0], s_axis_tvalid && s_axis_tready};
      out_vld <= pv[PIPE_N-1];
    end
  end

  // deltas
  logic signed [24:0] s1_dx, s1_dy, s1_dz;
  // basis products
  logic signed [56:0] s2_p [8];
  // dot products, Q.38
  logic signed [58:0] s3_fwd, s3_rgt, s3_up;
  logic [58:0] s3_dsum;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dx <= $signed({s_axis_tdata[23], s_axis_tdata[23:0]}) -
               $signed({cam.camera_x[23], cam.camera_x});
      s1_dy <= $signed({s_axis_tdata[47], s_axis_tdata[47:24]}) -
               $signed({cam.camera_y[23], cam.camera_y});
      s1_dz <= $signed({s_axis_tdata[71], s_axis_tdata[71:48]}) -
               $signed({cam.camera_z[23], cam.camera_z});
      s2_p[0] <= s1_dx * $signed(cam.fx);
      s2_p[1] <= s1_dy * $signed(cam.fy);
      s2_p[2] <= s1_dz * $signed(cam.sp);
      s2_p[3] <= s1_dx * $signed(cam.cy);
      s2_p[4] <= s1_dy * $signed(cam.sy);
      s2_p[5] <= s1_dx * $signed(cam.ux);
      s2_p[6] <= s1_dy * $signed(cam.uy);
      s2_p[7] <= s1_dz * $signed(cam.cp);
      s3_fwd  <= 59'(s2_p[0]) + 59'(s2_p[1]) + 59'(s2_p[2]);
      s3_rgt  <= 59'(s2_p[3]) + 59'(s2_p[4]);
      s3_up   <= 59'(s2_p[5]) + 59'(s2_p[6]) + 59'(s2_p[7]);
    end
  end

  assign s3_dsum = s3_fwd + 59'sd8192;

  // ratio divider: stage 0 holds the operands, each later stage one quotient bit
  logic [DEP_W-1:0] d_den [QT_W+1];
  logic [DEP_W-1:0] d_rem [QT_W+1][2];
  logic [QT_W-1:0]  d_sh  [QT_W+1][2];
  logic             d_vis [QT_W+1];
  logic [1:0]       d_neg [QT_W+1];
  logic [MAG_W-1:0] s3_mx, s3_my;

  assign s3_mx = mag14(s3_rgt);
  assign s3_my = mag14(s3_up);

  always_ff @(posedge clk) begin
    if (adv) begin
      d_vis[0]    <= s3_fwd >= VIS_MIN;
      d_den[0]    <= s3_dsum[DEP_W+13:14];
      d_neg[0]    <= {s3_up[58], s3_rgt[58]};
      d_rem[0][0] <= DEP_W'(s3_mx[MAG_W-1:32]);
      d_rem[0][1] <= DEP_W'(s3_my[MAG_W-1:32]);
      d_sh[0][0]  <= {s3_mx[31:0], 16'b0};
      d_sh[0][1]  <= {s3_my[31:0], 16'b0};
    end
  end

  for (genvar i = 0; i < QT_W; i++) begin : g_div
    for (genvar a = 0; a < 2; a++) begin : g_ax
      logic [DEP_W:0] trial;
      logic ge;
      assign trial = {d_rem[i][a], d_sh[i][a][QT_W-1]};
      assign ge    = trial >= {1'b0, d_den[i]};
      always_ff @(posedge clk) begin
        if (adv) begin
          d_rem[i+1][a] <= ge ? DEP_W'(trial - {1'b0, d_den[i]}) : trial[DEP_W-1:0];
          d_sh[i+1][a]  <= {d_sh[i][a][QT_W-2:0], ge};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        d_den[i+1] <= d_den[i];
        d_vis[i+1] <= d_vis[i];
        d_neg[i+1] <= d_neg[i];
      end
    end
  end

  // offset = ratio * K, in partial products
  logic [54:0]  m1_ll [2];
  logic [54:0]  m1_lh [2];
  logic [54:0]  m1_hl [2];
  logic [54:0]  m1_hh [2];
  logic [109:0] m2_a [2];
  logic [109:0] m2_b [2];
  logic [56:0]  m3_p [2];
  logic         m3_sat [2];
  logic [25:0]  m4_off [2];
  logic [57:0]  m4_sum [2];
  logic [1:0]   m1_neg, m2_neg, m3_neg, m4_neg;
  logic         m1_vis, m2_vis, m3_vis, m4_vis;
  logic [109:0] m3_full [2];
  logic [15:0]  ctr [2];
  logic signed [27:0] o_pos [2];
  logic [23:0]  o_val [2];
  logic [23:0]  out_x, out_y;
  logic         out_vis;

  assign ctr[0] = cam.centre_x;
  assign ctr[1] = cam.centre_y;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      m3_full[a] = m2_a[a] + m2_b[a];
      m4_sum[a]  = {1'b0, m3_p[a]} + (m3_neg[a] ? 58'd2147483647 : 58'd2147483648);
      o_pos[a]   = $signed({12'b0, ctr[a]}) +
                   (m4_neg[a] ? -$signed({2'b0, m4_off[a]}) : $signed({2'b0, m4_off[a]}));
      if (o_pos[a] > 28'sd8388607) begin
        o_val[a] = 24'h7FFFFF;
      end else if (o_pos[a] < -28'sd8388608) begin
        o_val[a] = 24'h800000;
      end else begin
        o_val[a] = o_pos[a][23:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 2; a++) begin
        m1_ll[a]  <= d_sh[QT_W][a][23:0]  * cam.k[30:0];
        m1_lh[a]  <= d_sh[QT_W][a][23:0]  * cam.k[K_W-1:31];
        m1_hl[a]  <= d_sh[QT_W][a][47:24] * cam.k[30:0];
        m1_hh[a]  <= d_sh[QT_W][a][47:24] * cam.k[K_W-1:31];
        m2_a[a]   <= 110'(m1_ll[a]) + (110'(m1_lh[a]) << 31);
        m2_b[a]   <= (110'(m1_hl[a]) << 24) + (110'(m1_hh[a]) << 55);
        m3_p[a]   <= m3_full[a][56:0];
        m3_sat[a] <= |m3_full[a][109:57];
        // beyond 2^25 the result clamps anyway
        m4_off[a] <= m3_sat[a] ? 26'd33554432 : m4_sum[a][57:32];
      end
      m1_neg  <= d_neg[QT_W];
      m2_neg  <= m1_neg;
      m3_neg  <= m2_neg;
      m4_neg  <= m3_neg;
      m1_vis  <= d_vis[QT_W];
      m2_vis  <= m1_vis;
      m3_vis  <= m2_vis;
      m4_vis  <= m3_vis;
      out_vis <= m4_vis;
      out_x   <= m4_vis ? o_val[0] : '0;
      out_y   <= m4_vis ? o_val[1] : '0;
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {out_y, out_x};
  assign m_axis_tuser  = out_vis;

  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 48'd0)
    else $error("hidden point with nonzero screen position");

  a_cfg_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !s_axis_tready)
    else $error("word accepted while camera setup runs");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(pv))
    else $error("pipeline moved during a stall");

endmodule
`default_nettype wire

// File: sv/wtsp_setup.sv
`default_nettype none
module wtsp_setup import wtsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output cam_t        cam
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SIN   = 3'd1;
  localparam logic [2:0] ST_BASIS = 3'd2;
  localparam logic [2:0] ST_KNUM  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;

  logic signed [23:0] camera_x, camera_y, camera_z;
  logic [15:0] view_yaw, view_pitch;
  logic [12:0] screen_width, screen_height;
  logic [14:0] field_of_view;

  logic [2:0]  state, idx, sub;
  logic [5:0]  cnt;
  logic [1:0]  q;
  logic [15:0] u;
  logic [30:0] z2, t;
  logic signed [31:0] sy, cy, sp, cp, sh, ch;
  logic signed [31:0] fx, fy, ux, uy;
  logic [K_W-1:0] knum;
  logic [31:0] rem;
  logic [30:0] dv;

  logic [16:0] fov_ang, ang_base, ang;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic [65:0] pmag;
  logic [65:0] prnd;
  logic signed [31:0] basis_val;
  logic signed [31:0] sin_mag, sin_val;
  logic signed [31:0] sh_eff, ch_eff;
  logic [31:0] trial;
  logic ge;

  always_comb begin
    fov_ang = (field_of_view == 15'd0) ? 17'd1 : {2'b0, field_of_view};
    case (idx[2:1])
      2'd0:    ang_base = {view_yaw, 1'b0};
      2'd1:    ang_base = {view_pitch, 1'b0};
      default: ang_base = fov_ang;
    endcase
    ang = ang_base + (idx[0] ? QUARTER : 17'd0);
  end

  assign sh_eff = (sh < 32'sd1) ? 32'sd1 : sh;
  assign ch_eff = (ch < 32'sd0) ? 32'sd0 : ch;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SIN: begin
        case (sub)
          3'd1: begin
            mul_a = {17'b0, u};
            mul_b = {17'b0, u};
          end
          3'd2: begin
            mul_a = {2'b0, SIN_C};
            mul_b = {2'b0, z2};
          end
          3'd3: begin
            mul_a = {2'b0, t};
            mul_b = {2'b0, z2};
          end
          3'd4: begin
            mul_a = {2'b0, t};
            mul_b = {17'b0, u};
          end
          default: ;
        endcase
      end
      ST_BASIS: begin
        case (idx[1:0])
          2'd0: begin
            mul_a = {sy[31], sy};
            mul_b = {cp[31], cp};
          end
          2'd1: begin
            mul_a = {cy[31], cy};
            mul_b = {cp[31], cp};
          end
          2'd2: begin
            mul_a = {sp[31], sp};
            mul_b = {sy[31], sy};
          end
          default: begin
            mul_a = {sp[31], sp};
            mul_b = {cy[31], cy};
          end
        endcase
      end
      ST_KNUM: begin
        mul_a = {17'b0, screen_width, 3'b0};
        mul_b = {1'b0, ch_eff};
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  // round half up by 30 bits, on the magnitude for negative products
  always_comb begin
    pmag = prod[65] ? 66'(-prod) : 66'(prod);
    prnd = prod[65] ? (pmag + 66'd536870911) : (pmag + 66'd536870912);
    basis_val = prod[65] ? -$signed(prnd[61:30]) : $signed(prnd[61:30]);
  end

  assign sin_mag = $signed(prod[46:15]);
  assign sin_val = q[1] ? -sin_mag : sin_mag;

  assign trial = {rem[30:0], knum[K_W-1]};
  assign ge    = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x      <= '0;
      camera_y      <= '0;
      camera_z      <= '0;
      view_yaw      <= '0;
      view_pitch    <= '0;
      screen_width  <= 13'd1024;
      screen_height <= 13'd768;
      field_of_view <= 15'd16384;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAMERA_X:      camera_x      <= cfg_data;
        REG_CAMERA_Y:      camera_y      <= cfg_data;
        REG_CAMERA_Z:      camera_z      <= cfg_data;
        REG_VIEW_YAW:      view_yaw      <= cfg_data[15:0];
        REG_VIEW_PITCH:    view_pitch    <= cfg_data[15:0];
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data[12:0];
        REG_SCREEN_HEIGHT: screen_height <= cfg_data[12:0];
        REG_FIELD_OF_VIEW: field_of_view <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // recompute the camera terms after reset and after every write
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state <= ST_SIN;
      idx   <= '0;
      sub   <= '0;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_SIN: begin
          sub <= sub + 3'd1;
          case (sub)
            3'd0: begin
              q <= ang[16:15];
              u <= ang[15] ? (16'd32768 - {1'b0, ang[14:0]}) : {1'b0, ang[14:0]};
            end
            3'd1: z2 <= prod[30:0];
            3'd2: t  <= SIN_B - prod[60:30];
            3'd3: t  <= SIN_A - prod[60:30];
            default: begin
              case (idx)
                3'd0:    sy <= sin_val;
                3'd1:    cy <= sin_val;
                3'd2:    sp <= sin_val;
                3'd3:    cp <= sin_val;
                3'd4:    sh <= sin_val;
                default: ch <= sin_val;
              endcase
              sub <= '0;
              if (idx == 3'd5) begin
                idx   <= '0;
                state <= ST_BASIS;
              end else begin
                idx <= idx + 3'd1;
              end
            end
          endcase
        end
        ST_BASIS: begin
          case (idx[1:0])
            2'd0:    fx <= basis_val;
            2'd1:    fy <= -basis_val;
            2'd2:    ux <= -basis_val;
            default: uy <= basis_val;
          endcase
          if (idx == 3'd3) begin
            state <= ST_KNUM;
          end
          idx <= idx + 3'd1;
        end
        ST_KNUM: begin
          knum  <= {prod[45:0], 16'b0};
          rem   <= '0;
          dv    <= sh_eff[30:0];
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          rem  <= ge ? (trial - {1'b0, dv}) : trial;
          knum <= {knum[K_W-2:0], ge};
          cnt  <= cnt + 6'd1;
          if (cnt == 6'(K_W - 1)) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cam.ready    = (state == ST_IDLE);
    cam.camera_x = camera_x;
    cam.camera_y = camera_y;
    cam.camera_z = camera_z;
    cam.fx       = fx;
    cam.fy       = fy;
    cam.sp       = sp;
    cam.cy       = cy;
    cam.sy       = sy;
    cam.ux       = ux;
    cam.uy       = uy;
    cam.cp       = cp;
    cam.k        = knum;
    cam.centre_x = {screen_width, 3'b0};
    cam.centre_y = {screen_height, 3'b0};
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> dv != 31'd0)
    else $error("scale divisor is zero");

  a_restart: assert property (@(posedge clk)
    cfg_we |=> state == ST_SIN && idx == 3'd0 && sub == 3'd0)
    else $error("write did not restart the camera setup");

endmodule
`default_nettype wire
